// File: rtl/rscs_pkg.sv
// Package for the relief shading block with cast shadows.
// Holds the configuration record, register indexes, state and command codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rscs_pkg;

	// Fixed widths of the data path.
	localparam int ElevW = 16;
	localparam int LineW = 40;
	localparam int GW    = 25;
	localparam int SqW   = 50;
	localparam int NW    = 25;
	localparam int RemW  = 42;
	localparam int QW    = 15;
	localparam int CW    = 16;

	// Algorithm constants.
	localparam int SeedOffset = 40000;
	localparam int Q14One     = 16384;
	localparam int ShadeMax   = 255;

	// Iteration counts of the shared square root and of the divider.
	localparam int Sq1Steps = 25;
	localparam int Sq2Steps = 15;
	localparam int DivSteps = 15;
	localparam int CntW     = 5;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_PIXEL_DISTANCE,
		REG_SUN_X,
		REG_SUN_Y,
		REG_TINT_COS,
		REG_TINT_SIN,
		REG_DROP_STEP,
		REG_SHADOW_OFF,
		REG_REVERSE_SCAN
	} reg_idx_t;

	typedef struct packed {
		logic        [15:0] pixel_distance;
		logic signed [15:0] sun_x;
		logic signed [15:0] sun_y;
		logic signed [15:0] tint_cos;
		logic signed [15:0] tint_sin;
		logic        [23:0] drop_step;
		logic               shadow_off;
		logic               reverse_scan;
	} cfg_t;

	// Position within a row.
	typedef enum logic [1:0] {
		PH_WAIT,
		PH_SEEDED,
		PH_ROW
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULSQ,
		ST_SQ1_LOAD,
		ST_SQ1,
		ST_DIV_LOAD,
		ST_DIV,
		ST_DIV_DONE,
		ST_CSQ,
		ST_SQ2,
		ST_SHMUL,
		ST_SHADE,
		ST_OUTW
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_MULSQ,
		CMD_SQ1_LOAD,
		CMD_SQ_STEP,
		CMD_DIV_LOAD,
		CMD_DIV_STEP,
		CMD_DIV_DONE,
		CMD_CSQ,
		CMD_SHMUL,
		CMD_SHADE,
		CMD_OUT_LOAD
	} cmd_t;

	typedef struct packed {
		logic seed;
		logic dark;
		logic div_skip;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// File: rtl/rscs_if.sv
// Channel interfaces of the relief shading block: pixel input, result output
// and configuration writes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

// Pixel channel: one elevation sample per beat.
interface rscs_pix_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] elevation;
	logic               row_start;
	modport source(output valid, output elevation, output row_start, input ready);
	modport sink(input valid, input elevation, input row_start, output ready);
endinterface

// Result channel: one shade per beat.
interface rscs_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] shade;
	logic       in_shadow;
	logic       run_last;
	modport source(output valid, output shade, output in_shadow, output run_last, input ready);
	modport sink(input valid, input shade, input in_shadow, input run_last, output ready);
endinterface

// Configuration write channel.
interface rscs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/relief_shade_with_cast_shadow.sv
// Relief shading with cast shadows, top level.
// The pixel channel takes the elevation samples of a raster row in scan
// order; row_start marks the first sample, which only seeds the row state.
// The result channel gives one shade per later pixel; the second pixel of a
// row gives two beats (the copy for the first pixel), run_last marks the last.
// The configuration channel writes one register per beat and is always ready;
// the user must write it only while the block is idle, which it does not enforce.
// A seeding pixel only updates the row state, a shadowed pixel goes straight
// to the output register and a lit pixel runs the shared bit-serial square root
// (25 steps for the slope length, 15 for the sine term) and the 15-step divider.
// When the slope length is zero or the quotient saturates, the divide is skipped.
// The output register frees the block to take the next pixel while a result
// waits.
// If the receiver stalls, the finished shade waits in the output register and
// the next lit or shadowed pixel holds in its last step until the register drains.
// Reset clears the row state (awaiting a row start), the shadow line and the
// output register, and loads the register defaults.
// Depends on rscs_pkg, rscs_if, rscs_cfg, rscs_ctrl and rscs_dp.
`timescale 1ns / 1ps
`default_nettype none
module relief_shade_with_cast_shadow (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rscs_pix_if.sink   pixel,
	rscs_res_if.source result,
	rscs_cfg_if.sink   cfg
);
	import rscs_pkg::*;

	cfg_t    regs;
	cmd_t    cmd;
	status_t status;

	// Configuration registers.
	rscs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Sequencer.
	rscs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_ready (pixel.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and row state.
	rscs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.regs      (regs),
		.elevation (pixel.elevation),
		.row_start (pixel.row_start),
		.status    (status),
		.result    (result)
	);

endmodule
`default_nettype wire

// File: rtl/rscs_cfg.sv
// Configuration register file of the relief shading block.
// Depends on rscs_pkg and the configuration channel interface.
`timescale 1ns / 1ps
`default_nettype none
module rscs_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rscs_cfg_if.sink         cfg,
	output rscs_pkg::cfg_t   regs
);
	import rscs_pkg::*;

	cfg_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// One register per beat, selected by the index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pixel_distance <= 16'd256;
			regs_q.sun_x          <= -16'sd11585;
			regs_q.sun_y          <= 16'sd11585;
			regs_q.tint_cos       <= 16'sd8607;
			regs_q.tint_sin       <= 16'sd13941;
			regs_q.drop_step      <= 24'd256;
			regs_q.shadow_off     <= 1'b0;
			regs_q.reverse_scan   <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (reg_idx_t'(cfg.index))
				REG_PIXEL_DISTANCE: regs_q.pixel_distance <= cfg.data[15:0];
				REG_SUN_X:          regs_q.sun_x          <= $signed(cfg.data[15:0]);
				REG_SUN_Y:          regs_q.sun_y          <= $signed(cfg.data[15:0]);
				REG_TINT_COS:       regs_q.tint_cos       <= $signed(cfg.data[15:0]);
				REG_TINT_SIN:       regs_q.tint_sin       <= $signed(cfg.data[15:0]);
				REG_DROP_STEP:      regs_q.drop_step      <= cfg.data;
				REG_SHADOW_OFF:     regs_q.shadow_off     <= cfg.data[0];
				REG_REVERSE_SCAN:   regs_q.reverse_scan   <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/rscs_ctrl.sv
// Controller of the relief shading block: sequences the data path through
// the products, two square roots and the divide. Depends on rscs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rscs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rscs_pkg::status_t status,
	output rscs_pkg::cmd_t         cmd
);
	import rscs_pkg::*;

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;

	// State and iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd = CMD_ACCEPT;
					if (status.seed) state_d = ST_IDLE;
					else if (status.dark) state_d = ST_OUTW;
					else state_d = ST_MULSQ;
				end
			end
			ST_MULSQ: begin
				cmd     = CMD_MULSQ;
				state_d = ST_SQ1_LOAD;
			end
			ST_SQ1_LOAD: begin
				cmd     = CMD_SQ1_LOAD;
				cnt_d   = CntW'(Sq1Steps - 1);
				state_d = ST_SQ1;
			end
			ST_SQ1: begin
				cmd = CMD_SQ_STEP;
				if (cnt_q == '0) state_d = ST_DIV_LOAD;
				else cnt_d = cnt_q - 1'b1;
			end
			ST_DIV_LOAD: begin
				cmd = CMD_DIV_LOAD;
				if (status.div_skip) begin
					state_d = ST_CSQ;
				end else begin
					cnt_d   = CntW'(DivSteps - 1);
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd = CMD_DIV_STEP;
				if (cnt_q == '0) state_d = ST_DIV_DONE;
				else cnt_d = cnt_q - 1'b1;
			end
			ST_DIV_DONE: begin
				cmd     = CMD_DIV_DONE;
				state_d = ST_CSQ;
			end
			ST_CSQ: begin
				cmd     = CMD_CSQ;
				cnt_d   = CntW'(Sq2Steps - 1);
				state_d = ST_SQ2;
			end
			ST_SQ2: begin
				cmd = CMD_SQ_STEP;
				if (cnt_q == '0) state_d = ST_SHMUL;
				else cnt_d = cnt_q - 1'b1;
			end
			ST_SHMUL: begin
				cmd     = CMD_SHMUL;
				state_d = ST_SHADE;
			end
			ST_SHADE: begin
				cmd     = CMD_SHADE;
				state_d = ST_OUTW;
			end
			ST_OUTW: begin
				if (status.out_free) begin
					cmd     = CMD_OUT_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A free output register always lets a finished pixel go back to idle.
	a_outw_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUTW && status.out_free) |=> state_q == ST_IDLE)
		else $error("finished pixel did not return to idle");

	// The first root runs exactly its step count.
	a_sq1_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ1_LOAD) |=> (state_q == ST_SQ1 && cnt_q == CntW'(Sq1Steps - 1)))
		else $error("square root started with wrong count");

	// Idle state is the only one that takes pixels.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("pixel taken outside idle");

endmodule
`default_nettype wire

// File: rtl/rscs_dp.sv
// Data path of the relief shading block: row state, shadow line, multipliers,
// the shared bit-serial square root, the divider and the output register.
// Depends on rscs_pkg and the result channel interface.
`timescale 1ns / 1ps
`default_nettype none
module rscs_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rscs_pkg::cmd_t        cmd,
	input  wire rscs_pkg::cfg_t        regs,
	input  wire logic signed [15:0]    elevation,
	input  wire logic                  row_start,
	output rscs_pkg::status_t          status,
	rscs_res_if.source                 result
);
	import rscs_pkg::*;

	// Row state.
	logic signed [ElevW-1:0] prev_q;
	logic signed [LineW-1:0] line_q;
	phase_t                  phase_q;
	logic                    pair_q;

	// Working registers.
	logic signed [GW-1:0]    g_q;
	logic        [SqW-1:0]   sqa_q, sqb_q;
	logic signed [40:0]      na_q;
	logic signed [32:0]      nb_q;
	logic        [SqW-1:0]   v_q, r_q, bit_q;
	logic        [RemW-1:0]  rem_q, den_q;
	logic        [QW-1:0]    q_q;
	logic                    neg_q;
	logic signed [CW-1:0]    c_q;
	logic signed [31:0]      pa_q, pb_q;
	logic        [7:0]       shade_q;
	logic                    dark_q;

	// Output register.
	logic [1:0]              out_cnt_q;
	logic [7:0]              out_shade_q;
	logic                    out_dark_q;

	// Input side arithmetic.
	logic signed [LineW-1:0] elev40, elev_sh, drop40, seed_line, lit_line, sat_line;
	logic signed [LineW:0]   line_dec;
	logic signed [ElevW:0]   diff17;
	logic signed [GW-1:0]    g_new;

	assign elev40    = LineW'(elevation);
	assign elev_sh   = elev40 <<< 8;
	assign drop40    = $signed({16'd0, regs.drop_step});
	assign seed_line = (elev40 - LineW'(SeedOffset)) <<< 8;
	assign lit_line  = elev_sh - drop40;
	assign line_dec  = (LineW+1)'(line_q) - (LineW+1)'(drop40);
	assign sat_line  = (line_dec < -(41'sd1 <<< 39)) ? -(40'sd1 <<< 39) : line_dec[LineW-1:0];
	assign diff17    = (ElevW+1)'(elevation) - (ElevW+1)'(prev_q);
	assign g_new     = regs.reverse_scan ? -$signed({diff17, 8'd0}) : $signed({diff17, 8'd0});

	// Divider set-up from the root and the numerator products.
	logic signed [RemW-1:0]  num;
	logic        [RemW-1:0]  mag, dvd, sat_lim;
	logic        [NW-1:0]    n;

	assign n       = r_q[NW-1:0];
	assign num     = RemW'(nb_q) - RemW'(na_q);
	assign mag     = num[RemW-1] ? RemW'(-num) : RemW'(num);
	assign dvd     = mag + RemW'(n >> 1);
	assign sat_lim = (RemW'(n) << 14) + RemW'(n);

	// Square root step, shared by both roots.
	logic [SqW-1:0] trial;
	assign trial = r_q + bit_q;

	// Products and shade.
	logic signed [49:0] gg;
	logic        [31:0] dd;
	logic signed [31:0] cc;
	logic signed [32:0] pdiff;
	logic signed [40:0] t41, d41;
	logic        [12:0] t_hi;

	assign gg    = g_q * g_q;
	assign dd    = regs.pixel_distance * regs.pixel_distance;
	assign cc    = c_q * c_q;
	assign pdiff = 33'(pa_q) - 33'(pb_q);
	assign d41   = 41'(pdiff);
	assign t41   = (d41 <<< 7) - d41 + 41'sd34091302912;
	assign t_hi  = t41[40:28];

	// Status to the controller.
	assign status.seed     = row_start || (phase_q == PH_WAIT);
	assign status.dark     = !regs.shadow_off && (elev_sh < line_q);
	assign status.div_skip = (n == '0) || (dvd >= sat_lim);
	assign status.out_free = (out_cnt_q == 2'd0);

	// Row state and shadow line, updated as each pixel is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			line_q  <= '0;
			phase_q <= PH_WAIT;
		end else if (cmd == CMD_ACCEPT) begin
			prev_q <= elevation;
			if (status.seed) begin
				line_q  <= seed_line;
				phase_q <= PH_SEEDED;
			end else begin
				line_q  <= status.dark ? sat_line : lit_line;
				phase_q <= PH_ROW;
			end
		end
	end

	// Working registers of the shading computation.
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				g_q     <= g_new;
				pair_q  <= (phase_q == PH_SEEDED);
				dark_q  <= status.dark;
				shade_q <= 8'd0;
			end
			CMD_MULSQ: begin
				sqa_q <= SqW'(unsigned'(gg));
				sqb_q <= SqW'(dd);
			end
			CMD_SQ1_LOAD: begin
				v_q   <= sqa_q + sqb_q;
				r_q   <= '0;
				bit_q <= SqW'(1) << 48;
				na_q  <= g_q * regs.sun_x;
				nb_q  <= $signed({1'b0, regs.pixel_distance}) * regs.sun_y;
			end
			CMD_SQ_STEP: begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			CMD_DIV_LOAD: begin
				rem_q <= dvd;
				den_q <= RemW'(n) << 14;
				q_q   <= '0;
				neg_q <= num[RemW-1];
				if (n == '0) c_q <= '0;
				else if (num[RemW-1]) c_q <= -CW'(Q14One);
				else c_q <= CW'(Q14One);
			end
			CMD_DIV_STEP: begin
				if (rem_q >= den_q) begin
					rem_q <= rem_q - den_q;
					q_q   <= {q_q[QW-2:0], 1'b1};
				end else begin
					q_q   <= {q_q[QW-2:0], 1'b0};
				end
				den_q <= den_q >> 1;
			end
			CMD_DIV_DONE: begin
				c_q <= neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
			end
			CMD_CSQ: begin
				v_q   <= (SqW'(1) << 28) - SqW'(unsigned'(cc));
				r_q   <= '0;
				bit_q <= SqW'(1) << 28;
			end
			CMD_SHMUL: begin
				pa_q <= c_q * regs.tint_cos;
				pb_q <= $signed({1'b0, r_q[QW-1:0]}) * regs.tint_sin;
			end
			CMD_SHADE: begin
				if (t41 < 0) shade_q <= 8'd0;
				else if (t_hi > 13'(ShadeMax)) shade_q <= 8'(ShadeMax);
				else shade_q <= t_hi[7:0];
			end
			default: begin
			end
		endcase
	end

	// Output register: the second pixel of a row gives two beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (cmd == CMD_OUT_LOAD) begin
			out_cnt_q <= pair_q ? 2'd2 : 2'd1;
		end else if (result.valid && result.ready) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_OUT_LOAD) begin
			out_shade_q <= shade_q;
			out_dark_q  <= dark_q;
		end
	end

	assign result.valid     = (out_cnt_q != 2'd0);
	assign result.shade     = out_shade_q;
	assign result.in_shadow = out_dark_q;
	assign result.run_last  = (out_cnt_q == 2'd1);

	// The output count never exceeds one pixel pair.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q != 2'd3)
		else $error("output beat count out of range");

	// A shadowed pixel always leaves with a zero shade.
	a_dark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_OUT_LOAD && dark_q) |=> out_shade_q == 8'd0)
		else $error("shadowed pixel with non-zero shade");

	// The output register is only reloaded once it has drained.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_OUT_LOAD) |-> out_cnt_q == 2'd0)
		else $error("output register overwritten");

endmodule
`default_nettype wire
